### hw/rtl/lms_adaptive_tap_controller_assert.svh
// Assertion macros for the LMS tap controller.
// Define ASSERT_OFF to compile every check out.
`ifndef LMS_ADAPTIVE_TAP_CONTROLLER_ASSERT_SVH
`define LMS_ADAPTIVE_TAP_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define LMS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lms check failed");
// expr must never be true outside reset
`define LMS_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("lms forbidden condition seen");
`else
`define LMS_ASSERT(label, clk, rstn, prop)
`define LMS_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

### hw/rtl/lms_pkg.sv
package lms_pkg;

    localparam int TAPS       = 3;
    localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam int SAMPLE_W   = 16;   // Q8.8
    localparam int GAIN_W     = 16;   // Q4.12
    localparam int WEIGHT_W   = 32;   // Q16.16
    localparam int DRIVE_W    = 32;   // Q16.16
    localparam int ERR_W      = SAMPLE_W + 1;

    // shared multiplier: covers weight*tap, gain*err and (gain*err)*tap
    localparam int MUL_A_W    = GAIN_W + ERR_W;
    localparam int MUL_B_W    = ERR_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 48;

    localparam int DRV_SHIFT  = 8;    // Q24.24 -> Q16.16
    localparam int UPD_SHIFT  = 12;   // Q21.28 -> Q16.16

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ADAPT_GAIN      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_LEVEL = CFG_ADDR_W'(1);

    localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(4096);
    localparam logic signed [SAMPLE_W-1:0] REF_RESET    = SAMPLE_W'(1280);
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(65536);

    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DRIVE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (DRIVE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    // arithmetic shift right, rounding toward zero
    function automatic prod_t trunc_shift(input prod_t p, input int sh);
        prod_t mask;
        prod_t q;
        mask = ~({PROD_W{1'b1}} << sh);
        q    = p >>> sh;
        if (p[PROD_W-1] && ((p & mask) != '0)) begin
            q = q + PROD_W'(1);
        end
        return q;
    endfunction

    function automatic weight_t sat_q16(input acc_t v);
        weight_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[WEIGHT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[WEIGHT_W-1:0];
        end else begin
            r = v[WEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/lms_mul.sv
// Shared signed multiplier with registered product.
module lms_mul import lms_pkg::*; (
    input  logic     aclk,
    input  mul_req_t req,
    output prod_t    prod
);

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    prod_t                     prod_reg;
    prod_t                     prod_next;

    assign op_a      = req.a;
    assign op_b      = req.b;
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/lms_adaptive_tap_controller.sv
// LMS adaptive tap controller, 3 taps, fixed point.
// Input stream s_*: one signed Q8.8 sensor sample per transfer.
// Output stream m_*: one signed Q16.16 drive value per sample.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata; index 0 = adapt_gain (Q4.12),
// index 1 = reference_level (Q8.8), other indexes are ignored. Write only
// while the block is idle.
// One 33x17 multiplier is shared by every product under a small sequencer.
// Sequence: the drive value is loaded into the output register in the emit
// step after the dot product. The weight update follows, and the next
// sample transfers only once the update is done, one sample at a
// time: the multiplier runs once per tap for the dot product, once for
// gain*error and once per tap for the update.
// Reset: taps clear to zero, weights load 1.0, registers take their reset
// values (gain 1.0, reference 5.0); no clearing sweep, ready right away.
// Stall: drive sits in an output register. If the previous result is still
// not taken when the next one is ready, the sequencer holds until it is.
`include "lms_adaptive_tap_controller_assert.svh"

module lms_adaptive_tap_controller import lms_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,     // [15:0] sample
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DRIVE_W-1:0]    m_tdata,     // [31:0] drive
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a sample
    localparam logic [2:0] ST_DOT   = 3'd1;  // weight*tap, accumulate previous
    localparam logic [2:0] ST_DLAST = 3'd2;  // last accumulate, start gain*err
    localparam logic [2:0] ST_EMIT  = 3'd3;  // load output register
    localparam logic [2:0] ST_UPD   = 3'd4;  // ge*tap, update previous weight
    localparam logic [2:0] ST_ULAST = 3'd5;  // last weight update

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TAPS - 1);

    logic [2:0]                   state_reg;
    logic signed [GAIN_W-1:0]     gain_reg;
    sample_t                      ref_reg;
    sample_t                      tap_reg    [TAPS];
    weight_t                      weight_reg [TAPS];
    logic signed [ERR_W-1:0]      err_reg;
    acc_t                         acc_reg;
    logic signed [MUL_A_W-1:0]    ge_reg;      // gain * error, Q13.20
    weight_t                      w_hold_reg;  // weight paired with product
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             wr_idx_reg;
    logic                         prod_vld_reg;
    logic [DRIVE_W-1:0]           drive_reg;
    logic                         m_tvalid_reg;

    mul_req_t                     mul_req;
    prod_t                        prod;
    sample_t                      tap_sel;
    weight_t                      weight_sel;
    acc_t                         acc_next;
    acc_t                         upd_sum;
    weight_t                      weight_next;
    logic                         emit_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = drive_reg;

    assign tap_sel    = tap_reg[idx_reg];
    assign weight_sel = weight_reg[idx_reg];

    // truncated weight*tap product into the dot-product sum
    assign acc_next    = acc_reg + ACC_W'(trunc_shift(prod, DRV_SHIFT));
    // truncated gain*err*tap onto the held weight
    assign upd_sum     = ACC_W'(w_hold_reg) + ACC_W'(trunc_shift(prod, UPD_SHIFT));
    assign weight_next = sat_q16(upd_sum);

    // output register free, or being drained this cycle
    assign emit_ok = !m_tvalid_reg || m_tready;

    // operand select for the shared multiplier
    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            ST_DOT: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(weight_sel);
                mul_req.b  = MUL_B_W'(tap_sel);
            end
            ST_DLAST: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(gain_reg);
                mul_req.b  = err_reg;
            end
            ST_UPD: begin
                mul_req.en = 1'b1;
                mul_req.a  = ge_reg;
                mul_req.b  = MUL_B_W'(tap_sel);
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    lms_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gain_reg     <= GAIN_RESET;
            ref_reg      <= REF_RESET;
            for (int i = 0; i < TAPS; i++) begin
                tap_reg[i]    <= '0;
                weight_reg[i] <= WEIGHT_RESET;
            end
            idx_reg      <= '0;
            wr_idx_reg   <= '0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_ADAPT_GAIN) begin
                    gain_reg <= cfg_wdata;
                end else if (cfg_addr == REG_REFERENCE_LEVEL) begin
                    ref_reg <= cfg_wdata;
                end
            end

            // in emit the output valid is owned by the emit step
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = TAPS - 1; i > 0; i--) begin
                            tap_reg[i] <= tap_reg[i-1];
                        end
                        tap_reg[0]   <= s_tdata;
                        err_reg      <= ERR_W'(ref_reg) - ERR_W'(sample_t'(s_tdata));
                        acc_reg      <= '0;
                        idx_reg      <= '0;
                        prod_vld_reg <= 1'b0;
                        state_reg    <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (prod_vld_reg) begin
                        acc_reg <= acc_next;
                    end
                    prod_vld_reg <= 1'b1;
                    if (idx_reg == IDX_LAST) begin
                        state_reg <= ST_DLAST;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DLAST: begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    // product register holds gain*err until the output frees up
                    if (emit_ok) begin
                        drive_reg    <= sat_q16(acc_reg);
                        m_tvalid_reg <= 1'b1;
                        ge_reg       <= prod[MUL_A_W-1:0];
                        idx_reg      <= '0;
                        prod_vld_reg <= 1'b0;
                        state_reg    <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    w_hold_reg   <= weight_sel;
                    wr_idx_reg   <= idx_reg;
                    prod_vld_reg <= 1'b1;
                    if (prod_vld_reg) begin
                        weight_reg[wr_idx_reg] <= weight_next;
                    end
                    if (idx_reg == IDX_LAST) begin
                        state_reg <= ST_ULAST;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_ULAST: begin
                    weight_reg[wr_idx_reg] <= weight_next;
                    state_reg              <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a transfer in always starts a busy stretch
    `LMS_ASSERT(a_busy_after_in, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    // a new result only comes out of the emit step
    `LMS_ASSERT(a_valid_from_emit, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
    // a stalled output keeps the sequencer parked in emit
    `LMS_ASSERT(a_emit_holds, aclk, aresetn, (state_reg == ST_EMIT && m_tvalid && !m_tready) |=> (state_reg == ST_EMIT))
    // tap index stays inside the delay line while the multiplier runs
    `LMS_ASSERT_NEVER(a_idx_range, aclk, aresetn, (state_reg == ST_DOT || state_reg == ST_UPD) && (idx_reg > IDX_LAST))

endmodule
